[rtl/mpqy_pkg.sv]
package mpqy_pkg;

  // Default build
  localparam int LEVELS_DEF      = 4;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 16;

  // Fixed field widths
  localparam int MAX_LEVELS = 4;
  localparam int LVL_W      = 2;
  localparam int REQ_W      = 2;
  localparam int THR_W      = 10;
  localparam int NUM_THR    = 3;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_NOKEY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE     = 2'd0,
    S_DONE     = 2'd1,
    S_RM_CMP   = 2'd2,
    S_RM_SHIFT = 2'd3
  } fsm_t;

  // Pop arbitration result
  typedef struct packed {
    logic                  hit;
    logic [LVL_W-1:0]      lvl;
    logic [MAX_LEVELS-1:0] yld;
  } pop_dec_t;

endpackage

[rtl/mpqy_ram.sv]
module mpqy_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mpqy_pop_sel.sv]
module mpqy_pop_sel #(
  parameter int LEVELS = mpqy_pkg::LEVELS_DEF
) (
  input  logic [LEVELS-1:0]          nonempty_i,
  input  logic [mpqy_pkg::THR_W-1:0] cnt_i [LEVELS],
  input  logic [mpqy_pkg::THR_W-1:0] thr_i [mpqy_pkg::NUM_THR],
  output mpqy_pkg::pop_dec_t         dec_o
);
  import mpqy_pkg::*;

  logic [LEVELS-1:0] yield_rdy;

  // last level never yields
  for (genvar g = 0; g < LEVELS; g++) begin : g_thr
    if (g < LEVELS - 1 && g < NUM_THR) begin : g_on
      assign yield_rdy[g] = (thr_i[g] != '0) && (cnt_i[g] >= thr_i[g]);
    end else begin : g_off
      assign yield_rdy[g] = 1'b0;
    end
  end

  // first non-empty level that is not yielding wins; yielding levels above it are flagged
  always_comb begin
    logic found;
    found = 1'b0;
    dec_o = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (!found && nonempty_i[i]) begin
        if (yield_rdy[i]) begin
          dec_o.yld[i] = 1'b1;
        end else begin
          dec_o.hit = 1'b1;
          dec_o.lvl = LVL_W'(i);
          found     = 1'b1;
        end
      end
    end
  end

endmodule

[rtl/multilevel_priority_queue_yield_core.sv]
// Sequencing: push, pop and idle requests go to S_DONE, which loads the output register once
//   it is free; a remove on a non-empty level first walks the level in S_RM_CMP/S_RM_SHIFT,
//   one key-store access per queued entry. Flow: one item at a time; the next item is taken
//   the cycle after the result is loaded into the output register.
// Reset: rst_n synchronous, active low; clears fill, head, pop counters, thresholds and
//   the output valid. The key store is not cleared (only queued entries are ever read).
module multilevel_priority_queue_yield_core #(
  parameter int LEVELS      = mpqy_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = mpqy_pkg::LEVEL_DEPTH_DEF,
  parameter int KEY_BITS    = mpqy_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpqy_pkg::REQ_W-1:0]    in_req_type,
  input  logic [mpqy_pkg::LVL_W-1:0]    in_level,
  input  logic [KEY_BITS-1:0]           in_task_key,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [KEY_BITS-1:0]           out_key,
  output logic [mpqy_pkg::LVL_W-1:0]    out_level,
  output logic                          out_all_empty,
  // threshold registers
  input  logic                          cfg_we,
  input  logic [mpqy_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpqy_pkg::THR_W-1:0]    cfg_wdata
);
  import mpqy_pkg::*;

  // Ring position, fill count and level index widths. Key store is addressed
  // as {level, ring position}.
  localparam int PW        = $clog2(LEVEL_DEPTH);
  localparam int FW        = $clog2(LEVEL_DEPTH + 1);
  localparam int LW        = $clog2(LEVELS);
  localparam int RAM_DEPTH = LEVELS * (2 ** PW);
  localparam int AW        = LW + PW;
  localparam logic [PW-1:0] LAST_POS = PW'(LEVEL_DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F  = FW'(LEVEL_DEPTH);

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fsm_t                state_r, state_nxt;

  // per-level bookkeeping
  logic [FW-1:0]       fill_r [LEVELS];
  logic [FW-1:0]       fill_nxt [LEVELS];
  logic [PW-1:0]       head_r [LEVELS];
  logic [PW-1:0]       head_nxt [LEVELS];
  logic [THR_W-1:0]    cnt_r [LEVELS];
  logic [THR_W-1:0]    cnt_nxt [LEVELS];
  logic [THR_W-1:0]    thr_r [NUM_THR];
  logic [THR_W-1:0]    thr_nxt [NUM_THR];

  // request in flight (remove walk)
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [FW-1:0]       k_r, k_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [PW-1:0]       wpos_r, wpos_nxt;

  // pending result
  status_t             res_status_r, res_status_nxt;
  logic                res_hit_r, res_hit_nxt;
  logic [LVL_W-1:0]    res_lvl_r, res_lvl_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [LVL_W-1:0]    out_level_r, out_level_nxt;
  logic                out_empty_r, out_empty_nxt;

  // key store port
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0] ram_wdata, ram_rdata;

  // ---------------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------------
  logic              in_fire, out_free;
  logic              lv_ok, push_ok, rm_start;
  logic [LW-1:0]     lv_idx;
  logic [FW:0]       tail_sum;
  logic [PW-1:0]     tail_pos;
  logic [FW:0]       k_plus;
  logic              more, match;
  logic [LEVELS-1:0] nonempty;
  pop_dec_t          pop_dec;
  logic [LW-1:0]     pop_lvl;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign lv_ok    = (32'(in_level) < LEVELS);
  assign lv_idx   = in_level[LW-1:0];
  assign push_ok  = lv_ok && (fill_r[lv_idx] != DEPTH_F);
  assign rm_start = (req_t'(in_req_type) == REQ_REMOVE) && lv_ok && (fill_r[lv_idx] != '0);

  // tail = (head + fill) mod depth; sum stays below twice the depth
  assign tail_sum = (FW+1)'(head_r[lv_idx]) + (FW+1)'(fill_r[lv_idx]);
  assign tail_pos = (tail_sum >= (FW+1)'(LEVEL_DEPTH)) ?
                    PW'(tail_sum - (FW+1)'(LEVEL_DEPTH)) : PW'(tail_sum);

  // remove walk: another entry behind the current one?
  assign k_plus = {1'b0, k_r} + 1'b1;
  assign more   = (k_plus < {1'b0, fill_r[lvl_r]});
  assign match  = (ram_rdata == key_r);

  for (genvar g = 0; g < LEVELS; g++) begin : g_ne
    assign nonempty[g] = (fill_r[g] != '0);
  end

  mpqy_pop_sel #(
    .LEVELS (LEVELS)
  ) u_pop_sel (
    .nonempty_i (nonempty),
    .cnt_i      (cnt_r),
    .thr_i      (thr_r),
    .dec_o      (pop_dec)
  );

  assign pop_lvl = pop_dec.lvl[LW-1:0];

  mpqy_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = rm_start ? S_RM_CMP : S_DONE;
        end
      end
      S_RM_CMP: begin
        if (more) begin
          state_nxt = match ? S_RM_SHIFT : S_RM_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RM_SHIFT: begin
        state_nxt = more ? S_RM_SHIFT : S_DONE;
      end
      S_DONE: begin
        state_nxt = out_free ? S_IDLE : S_DONE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and key store control
  // ---------------------------------------------------------------------------
  always_comb begin
    fill_nxt       = fill_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    thr_nxt        = thr_r;
    lvl_nxt        = lvl_r;
    key_nxt        = key_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    wpos_nxt       = wpos_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_lvl_nxt    = res_lvl_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_level_nxt  = out_level_r;
    out_empty_nxt  = out_empty_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = '0;
    ram_raddr      = '0;
    ram_wdata      = '0;

    // user issues config writes only while idle (unenforced); index beyond list is dropped
    if (cfg_we && (32'(cfg_index) < NUM_THR)) begin
      thr_nxt[cfg_index] = cfg_wdata;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          lvl_nxt     = lv_idx;
          key_nxt     = in_task_key;
          res_hit_nxt = 1'b0;
          res_lvl_nxt = '0;
          unique case (req_t'(in_req_type))
            REQ_PUSH: begin
              if (push_ok) begin
                ram_we           = 1'b1;
                ram_waddr        = {lv_idx, tail_pos};
                ram_wdata        = in_task_key;
                fill_nxt[lv_idx] = fill_r[lv_idx] + 1'b1;
                res_status_nxt   = STAT_OK;
              end else begin
                res_status_nxt   = STAT_FULL;
              end
            end
            REQ_POP: begin
              // skipped levels that hit their threshold restart their count
              for (int i = 0; i < LEVELS; i++) begin
                if (pop_dec.yld[i]) begin
                  cnt_nxt[i] = '0;
                end
              end
              if (pop_dec.hit) begin
                ram_re            = 1'b1;
                ram_raddr         = {pop_lvl, head_r[pop_lvl]};
                head_nxt[pop_lvl] = pos_inc(head_r[pop_lvl]);
                fill_nxt[pop_lvl] = fill_r[pop_lvl] - 1'b1;
                cnt_nxt[pop_lvl]  = cnt_r[pop_lvl] + 1'b1;
                res_hit_nxt       = 1'b1;
                res_lvl_nxt       = pop_dec.lvl;
                res_status_nxt    = STAT_OK;
              end else begin
                res_status_nxt    = STAT_EMPTY;
              end
            end
            REQ_REMOVE: begin
              if (rm_start) begin
                ram_re    = 1'b1;
                ram_raddr = {lv_idx, head_r[lv_idx]};
                pos_nxt   = head_r[lv_idx];
                k_nxt     = '0;
              end else begin
                res_status_nxt = STAT_NOKEY;
              end
            end
            REQ_NONE: begin
              res_status_nxt = STAT_OK;
            end
          endcase
        end
      end

      // compare entry k; on a hit, start pulling later entries forward
      S_RM_CMP: begin
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = {lvl_r, pos_inc(pos_r)};
          pos_nxt   = pos_inc(pos_r);
          wpos_nxt  = pos_r;
          k_nxt     = k_plus[FW-1:0];
        end else if (match) begin
          fill_nxt[lvl_r] = fill_r[lvl_r] - 1'b1;
          res_status_nxt  = STAT_OK;
        end else begin
          res_status_nxt  = STAT_NOKEY;
        end
      end

      // write entry k into slot k-1 while reading entry k+1
      S_RM_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = {lvl_r, wpos_r};
        ram_wdata = ram_rdata;
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = {lvl_r, pos_inc(pos_r)};
          pos_nxt   = pos_inc(pos_r);
          wpos_nxt  = pos_r;
          k_nxt     = k_plus[FW-1:0];
        end else begin
          fill_nxt[lvl_r] = fill_r[lvl_r] - 1'b1;
          res_status_nxt  = STAT_OK;
        end
      end

      // hand the result to the output register; popped key comes from the store
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_hit_r ? ram_rdata : '0;
          out_level_nxt  = res_lvl_r;
          out_empty_nxt  = ~|nonempty;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      for (int i = 0; i < NUM_THR; i++) begin
        thr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      thr_r       <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    key_r        <= key_nxt;
    k_r          <= k_nxt;
    pos_r        <= pos_nxt;
    wpos_r       <= wpos_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_lvl_r    <= res_lvl_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_level_r  <= out_level_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_level     = out_level_r;
  assign out_all_empty = out_empty_r;

endmodule

[test/multilevel_priority_queue_yield_core_tb.sv]
import mpqy_pkg::*;

typedef struct packed {
  status_t                 status;
  logic [KEY_BITS_DEF-1:0] key;
  logic [LVL_W-1:0]        lvl;
  logic                    all_empty;
} queue_result_t;

class priority_queue_scoreboard;
  // level contents kept in queue order, slot 0 is the head
  logic [KEY_BITS_DEF-1:0] slots[LEVELS_DEF][LEVEL_DEPTH_DEF];
  int                      fill[LEVELS_DEF];
  logic [THR_W-1:0]        pop_count[LEVELS_DEF];
  logic [THR_W-1:0]        threshold[NUM_THR];
  queue_result_t           expected_results[$];

  int errors = 0;
  int checked = 0;
  int n_push = 0, n_full = 0, n_pop = 0, n_yield = 0, n_nothing = 0;
  int n_remove = 0, n_nokey = 0, n_other = 0;

  function new();
    foreach (fill[i]) begin
      fill[i] = 0;
      pop_count[i] = '0;
    end
    foreach (threshold[i]) threshold[i] = '0;
  endfunction

  function void set_threshold(int idx, logic [THR_W-1:0] val);
    if (idx < NUM_THR) threshold[idx] = val;
  endfunction

  // the lowest level never yields
  function logic [THR_W-1:0] yield_limit(int lv);
    if (lv + 1 >= LEVELS_DEF || lv >= NUM_THR) return '0;
    return threshold[lv];
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void note_request(req_t req, logic [LVL_W-1:0] lv, logic [KEY_BITS_DEF-1:0] key);
    queue_result_t res;
    res.status = STAT_OK;
    res.key = '0;
    res.lvl = '0;
    res.all_empty = 1'b1;
    case (req)
      REQ_PUSH: begin
        n_push++;
        if (lv >= LEVELS_DEF || fill[lv] >= LEVEL_DEPTH_DEF) begin
          res.status = STAT_FULL;
          n_full++;
        end else begin
          slots[lv][fill[lv]] = key;
          fill[lv]++;
        end
      end
      REQ_POP: begin
        n_pop++;
        res.status = STAT_EMPTY;
        for (int i = 0; i < LEVELS_DEF; i++) begin
          if (fill[i] == 0) continue;
          if (yield_limit(i) != 0 && pop_count[i] >= yield_limit(i)) begin
            pop_count[i] = '0;
            n_yield++;
            continue;
          end
          res.status = STAT_OK;
          res.key = slots[i][0];
          res.lvl = LVL_W'(i);
          for (int k = 0; k + 1 < fill[i]; k++) slots[i][k] = slots[i][k + 1];
          fill[i]--;
          pop_count[i]++;
          break;
        end
        if (res.status == STAT_EMPTY) n_nothing++;
      end
      REQ_REMOVE: begin
        n_remove++;
        res.status = STAT_NOKEY;
        if (lv < LEVELS_DEF) begin
          for (int k = 0; k < fill[lv]; k++) begin
            if (slots[lv][k] == key) begin
              for (int j = k; j + 1 < fill[lv]; j++) slots[lv][j] = slots[lv][j + 1];
              fill[lv]--;
              res.status = STAT_OK;
              break;
            end
          end
        end
        if (res.status == STAT_NOKEY) n_nokey++;
      end
      default: n_other++;
    endcase
    foreach (fill[i]) if (fill[i] != 0) res.all_empty = 1'b0;
    expected_results.push_back(res);
  endfunction

  task report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR: result %0d, %s: got %0h, expected %0h", checked, what, got, want);
    errors++;
  endtask

  task check_result(input logic [1:0] st, input logic [KEY_BITS_DEF-1:0] key,
                    input logic [LVL_W-1:0] lvl, input logic empty_flag);
    queue_result_t want;
    checked++;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no request outstanding", longint'(st), 64'd0);
      return;
    end
    want = expected_results.pop_front();
    if (st !== want.status)
      report_mismatch("status", longint'(st), longint'(want.status));
    if (key !== want.key)
      report_mismatch("key", longint'(key), longint'(want.key));
    if (lvl !== want.lvl)
      report_mismatch("level", longint'(lvl), longint'(want.lvl));
    if (empty_flag !== want.all_empty)
      report_mismatch("all_empty", longint'(empty_flag), longint'(want.all_empty));
  endtask
endclass

module multilevel_priority_queue_yield_core_tb;

  // threshold register map
  localparam int THR_IDX_L0    = 0;
  localparam int THR_IDX_L1    = 1;
  localparam int THR_IDX_L2    = 2;
  localparam int THR_IDX_SPARE = 3;   // decoded by nobody, writes must be dropped

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 180;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [REQ_W-1:0]        in_req_type;
  logic [LVL_W-1:0]        in_level;
  logic [KEY_BITS_DEF-1:0] in_task_key;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              out_status;
  logic [KEY_BITS_DEF-1:0] out_key;
  logic [LVL_W-1:0]        out_level;
  logic                    out_all_empty;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [THR_W-1:0]        cfg_wdata;

  priority_queue_scoreboard sb;

  // percent of cycles each side holds off
  int send_idle_pct;
  int recv_idle_pct;
  int n_settings;

  // per-phase thresholds for levels 0..2; zero, one and the top value all show up,
  // and some phases lower a threshold below counts left over from the phase before
  int thr_plan[PHASES][NUM_THR] = '{'{1, 2, 3}, '{0, 0, 0}, '{1023, 1, 5},
                                    '{2, 1023, 0}, '{1, 1, 1}, '{7, 3, 1023}};

  multilevel_priority_queue_yield_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_level      (in_level),
    .in_task_key   (in_task_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_level     (out_level),
    .out_all_empty (out_all_empty),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Result side: ready is redrawn at every falling edge, so stalls can hit any result
  // that waits in the output register, after push, pop and remove alike.
  always @(negedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Outputs are read at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_key, out_level, out_all_empty);
  end

  // Keys: the extremes, a tiny pool so duplicates and repeat matches happen, and
  // full-width random values so every key bit toggles.
  function automatic logic [KEY_BITS_DEF-1:0] random_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KEY_BITS_DEF'($urandom_range(7));
      default: return KEY_BITS_DEF'($urandom);
    endcase
  endfunction

  // Offer one item. Valid is left high after acceptance; the next call either
  // replaces the payload or drops valid at the following falling edge, so valid
  // never sees two assignments in one step. With hold set, the sender first
  // waits for every outstanding result to drain.
  task automatic send_request(input req_t req, input logic [LVL_W-1:0] lv,
                              input logic [KEY_BITS_DEF-1:0] key, input bit hold = 1'b0);
    @(negedge clk);
    if (hold) begin
      in_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
      @(negedge clk);
    end
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_level    <= lv;
    in_task_key <= key;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, lv, key);
  endtask

  // Drop valid and wait until every result is back; the block is idle then.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input int idx, input logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= val;
    sb.set_threshold(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly single requests aimed at a favored level, plus occasional push bursts
  // that can run a level past full. Removes usually name a key that is queued there.
  task automatic run_random_phase(input int n_items, input bit push_heavy);
    int sent;
    int hot;
    int pick;
    int burst;
    req_t req;
    logic [LVL_W-1:0] lv;
    logic [KEY_BITS_DEF-1:0] key;
    sent = 0;
    hot = $urandom_range(LEVELS_DEF - 1);
    while (sent < n_items) begin
      if ($urandom_range(99) < 4) begin
        lv = LVL_W'($urandom_range(LEVELS_DEF - 1));
        burst = $urandom_range(LEVEL_DEPTH_DEF + 2, 4);
        repeat (burst) send_request(REQ_PUSH, lv, random_key());
        sent += burst;
        continue;
      end
      lv = $urandom_range(1) ? LVL_W'(hot) : LVL_W'($urandom_range(LEVELS_DEF - 1));
      key = random_key();
      pick = $urandom_range(99);
      if (pick < 3) req = REQ_NONE;
      else if (pick < (push_heavy ? 55 : 33)) req = REQ_PUSH;
      else if (pick < 83) req = REQ_POP;
      else begin
        req = REQ_REMOVE;
        if (sb.fill[lv] != 0 && $urandom_range(3) != 0)
          key = sb.slots[lv][$urandom_range(sb.fill[lv] - 1)];
      end
      // now and then hold back until the block has fully drained
      send_request(req, lv, key, $urandom_range(99) < 2);
      sent++;
    end
  endtask

  initial begin
    sb = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_NONE;
    in_level    = '0;
    in_task_key = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    send_idle_pct = 22;
    recv_idle_pct = 63;
    n_settings = 1;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, thresholds still at reset (no yielding):
    // pop and remove on an empty queue, the unused request kind, extreme keys,
    // the first of two duplicate keys removed, a remove miss, a tail remove,
    // then drain to empty including one pop too many.
    send_request(REQ_POP,    2'd0, 16'h0000);
    send_request(REQ_REMOVE, 2'd2, 16'h0005);
    send_request(REQ_NONE,   2'd1, 16'hFFFF);
    send_request(REQ_PUSH,   2'd0, 16'hFFFF);
    send_request(REQ_PUSH,   2'd0, 16'h0000);
    send_request(REQ_PUSH,   2'd1, 16'h0001);
    send_request(REQ_PUSH,   2'd3, 16'h8000);
    send_request(REQ_PUSH,   2'd3, 16'h7FFF);
    send_request(REQ_PUSH,   2'd3, 16'h8000);
    send_request(REQ_REMOVE, 2'd3, 16'h8000);
    send_request(REQ_REMOVE, 2'd3, 16'h0001);
    send_request(REQ_REMOVE, 2'd0, 16'h0000);
    repeat (5) send_request(REQ_POP, 2'd0, 16'h0000);

    // Directed, levels 0 to 2 yield after one pop: a yield handing the pop to a
    // lower level, and a yield that leaves the pop with nothing although level 0
    // still holds a key. The spare index is written too and must change nothing.
    wait_idle();
    write_threshold(THR_IDX_L0, 10'd1);
    write_threshold(THR_IDX_L1, 10'd1);
    write_threshold(THR_IDX_L2, 10'd1);
    write_threshold(THR_IDX_SPARE, 10'd1023);
    n_settings++;
    send_request(REQ_PUSH, 2'd0, 16'h00AA);
    send_request(REQ_PUSH, 2'd0, 16'h00BB);
    send_request(REQ_PUSH, 2'd1, 16'h00CC);
    send_request(REQ_PUSH, 2'd2, 16'h00DD);
    repeat (4) send_request(REQ_POP, 2'd0, 16'h0000);
    send_request(REQ_PUSH, 2'd0, 16'h00EE);
    send_request(REQ_POP,  2'd0, 16'h0000);
    send_request(REQ_POP,  2'd0, 16'h0000);

    // Random phases: two per idling pattern (sender light / receiver heavy,
    // then swapped, then none), alternating push-heavy and pop-heavy mixes.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      send_idle_pct = (p < 2) ? 22 : (p < 4) ? 63 : 0;
      recv_idle_pct = (p < 2) ? 63 : (p < 4) ? 22 : 0;
      write_threshold(THR_IDX_L0, THR_W'(thr_plan[p][THR_IDX_L0]));
      write_threshold(THR_IDX_L1, THR_W'(thr_plan[p][THR_IDX_L1]));
      write_threshold(THR_IDX_L2, THR_W'(thr_plan[p][THR_IDX_L2]));
      write_threshold(THR_IDX_SPARE, THR_W'($urandom));
      n_settings++;
      run_random_phase(PHASE_ITEMS, (p % 2) == 0);
    end

    // Drain, then give a slow remove time to show any stray result.
    wait_idle();
    repeat (2 * LEVEL_DEPTH_DEF + 4) @(posedge clk);

    $display("Ran %0d push (%0d full), %0d pop (%0d empty, %0d yield), %0d remove (%0d miss)",
             sb.n_push, sb.n_full, sb.n_pop, sb.n_nothing, sb.n_yield,
             sb.n_remove, sb.n_nokey);
    $display("%0d no-ops; %0d results checked over %0d threshold settings, three idle patterns",
             sb.n_other, sb.checked, n_settings);
    if (sb.errors == 0) begin
      $display("multilevel_priority_queue_yield_core: match");
    end else begin
      $display("multilevel_priority_queue_yield_core: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (long removes, heavy stalls).
  initial begin
    #20000000;
    $display("multilevel_priority_queue_yield_core: mismatch");
    $finish;
  end

endmodule
